// ===== hdl/dqnp_pkg.sv =====
// Shared types and constants for the DNS query name parser.
package dqnp_pkg;

  // Packet position where the first name character sits.
  localparam logic [3:0] NAME_START = 4'd13;
  localparam logic [7:0] LABEL_LIMIT = 8'h20;
  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [2:0] TAIL_BYTES = 3'd4;
  localparam logic [7:0] MAX_NAME_RESET = 8'hFF;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_LONG  = 2'd2,
    ST_TRUNC = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_AFTER  = 2'd2,
    PH_FAILED = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        is_summary;
    logic [7:0]  name_char;
    logic [7:0]  name_length;
    logic [7:0]  dot_count;
    logic [15:0] query_type;
    status_t     status;
  } out_t;

endpackage

// ===== hdl/dns_query_name_parser.sv =====
// DNS query name parser: packet bytes in, name characters and a summary out.
// A result passes through the result queue and then the output register before it is on out_data.
// Throughput: one byte per cycle while in_ready is high, set by the parse update in the front end.
// in_ready drops only when the result queue is full behind a stalled consumer.
// Reset (rst_n low at a clock edge) clears the parse state and the queue and sets
// the name length limit to 255.
module dns_query_name_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_wr_en,
  input  logic [7:0]     cfg_wr_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  dqnp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output dqnp_pkg::out_t out_data
);

  logic           in_fire;
  logic           res_valid;
  dqnp_pkg::out_t res_item;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  dqnp_pkg::out_t q_item;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  dqnp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_fire    (in_fire),
    .in_item    (in_data),
    .res_valid  (res_valid),
    .res_item   (res_item)
  );

  dqnp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire && res_valid),
    .push_item(res_item),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  dqnp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== hdl/dqnp_front.sv =====
// Front end: accepts packet bytes, tracks the parse and produces result items.
module dqnp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic          in_fire,
  input  dqnp_pkg::in_t in_item,
  output logic          res_valid,
  output dqnp_pkg::out_t res_item
);

  logic [3:0]        pos_r, pos_nxt;
  dqnp_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]        chars_r, chars_nxt;
  logic [7:0]        dots_r, dots_nxt;
  logic [15:0]       type_r, type_nxt;
  logic [2:0]        after_r, after_nxt;
  dqnp_pkg::status_t err_r, err_nxt;
  logic [7:0]        max_len_r;

  logic [7:0]        b;
  logic              emit;
  logic [7:0]        ch;
  dqnp_pkg::status_t st;

  always_comb begin
    b         = in_item.packet_byte;
    emit      = 1'b0;
    ch        = 8'h00;
    st        = dqnp_pkg::ST_OK;
    pos_nxt   = (pos_r == dqnp_pkg::NAME_START) ? pos_r : pos_r + 4'd1;
    phase_nxt = phase_r;
    chars_nxt = chars_r;
    dots_nxt  = dots_r;
    type_nxt  = type_r;
    after_nxt = after_r;
    err_nxt   = err_r;

    if (phase_r == dqnp_pkg::PH_HEADER && pos_r == dqnp_pkg::NAME_START) begin
      phase_nxt = dqnp_pkg::PH_NAME;
    end

    case (phase_nxt)
      dqnp_pkg::PH_NAME: begin
        if (chars_r >= max_len_r) begin
          phase_nxt = dqnp_pkg::PH_FAILED;
          err_nxt   = dqnp_pkg::ST_LONG;
        end else if (b == 8'h00) begin
          phase_nxt = dqnp_pkg::PH_AFTER;
        end else begin
          emit      = 1'b1;
          chars_nxt = chars_r + 8'd1;
          if (b < dqnp_pkg::LABEL_LIMIT) begin
            ch       = dqnp_pkg::DOT_CHAR;
            dots_nxt = dots_r + 8'd1;
          end else begin
            ch = b;
          end
          if (chars_nxt >= max_len_r) begin
            phase_nxt = dqnp_pkg::PH_FAILED;
            err_nxt   = dqnp_pkg::ST_LONG;
          end
        end
      end
      dqnp_pkg::PH_AFTER: begin
        if (after_r < 3'd2) begin
          type_nxt = {type_r[7:0], b};
        end
        if (after_r < dqnp_pkg::TAIL_BYTES) begin
          after_nxt = after_r + 3'd1;
        end
      end
      default: begin
      end
    endcase

    if (phase_nxt == dqnp_pkg::PH_FAILED) begin
      st = err_nxt;
    end else if (phase_nxt == dqnp_pkg::PH_HEADER) begin
      st = dqnp_pkg::ST_SHORT;
    end else if (phase_nxt == dqnp_pkg::PH_AFTER && after_nxt >= dqnp_pkg::TAIL_BYTES) begin
      st = dqnp_pkg::ST_OK;
    end else begin
      st = dqnp_pkg::ST_TRUNC;
    end

    res_item = '0;
    if (in_item.last_byte) begin
      res_valid            = 1'b1;
      res_item.is_summary  = 1'b1;
      res_item.name_length = (st == dqnp_pkg::ST_OK) ? chars_nxt : 8'h00;
      res_item.dot_count   = dots_nxt;
      res_item.query_type  = (st == dqnp_pkg::ST_OK) ? type_nxt : 16'h0000;
      res_item.status      = st;
      // The summary closes the packet; the next byte starts a new header.
      pos_nxt   = '0;
      phase_nxt = dqnp_pkg::PH_HEADER;
      chars_nxt = '0;
      dots_nxt  = '0;
      type_nxt  = '0;
      after_nxt = '0;
      err_nxt   = dqnp_pkg::ST_OK;
    end else begin
      res_valid          = emit;
      res_item.name_char = ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      phase_r   <= dqnp_pkg::PH_HEADER;
      chars_r   <= '0;
      dots_r    <= '0;
      type_r    <= '0;
      after_r   <= '0;
      err_r     <= dqnp_pkg::ST_OK;
      max_len_r <= dqnp_pkg::MAX_NAME_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      if (in_fire) begin
        pos_r   <= pos_nxt;
        phase_r <= phase_nxt;
        chars_r <= chars_nxt;
        dots_r  <= dots_nxt;
        type_r  <= type_nxt;
        after_r <= after_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_item.last_byte |=>
      phase_r == dqnp_pkg::PH_HEADER && pos_r == 4'd0 && chars_r == 8'd0)
    else $error("packet state not cleared after last byte");

  a_header_no_chars: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == dqnp_pkg::PH_HEADER |-> chars_r == 8'd0 && dots_r == 8'd0)
    else $error("name counters moved during header skip");

  a_error_only_failed: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != dqnp_pkg::ST_OK |-> phase_r == dqnp_pkg::PH_FAILED)
    else $error("error code set outside failed phase");

endmodule

// ===== hdl/dqnp_queue.sv =====
// Short result queue between the parse front end and the output stage.
module dqnp_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dqnp_pkg::out_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output dqnp_pkg::out_t q_item
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  dqnp_pkg::out_t  entry_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r, count_nxt;

  assign full    = (count_r == FullCnt);
  assign q_valid = (count_r != '0);
  assign q_item  = entry_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + CntW'(1);
      2'b01:   count_nxt = count_r - CntW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
      end
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("push into a full result queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from an empty result queue");

endmodule

// ===== hdl/dqnp_back.sv =====
// Back end: output register that hands queued results to the consumer.
module dqnp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  dqnp_pkg::out_t q_item,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output dqnp_pkg::out_t out_data
);

  logic           out_valid_r;
  dqnp_pkg::out_t out_data_r;

  // Pop a queued item when the register is empty or its transfer completes.
  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= q_item;
    end
  end

endmodule
